// ===== design/lp2c_pkg.sv =====
// Package for the lidar polar to Cartesian converter.
// Field widths, angle constants, CORDIC arctangent table and the stage word type.
// No dependencies.
`default_nettype none
package lp2c_pkg;

  localparam int RANGE_W     = 16;
  localparam int INDEX_W     = 11;
  localparam int RES_W       = 16;
  localparam int OUT_W       = 17;
  localparam int PIDX_W      = 27;
  localparam int QUO_W       = 6;
  localparam int REM_W       = 23;
  localparam int ANG_W       = 22;
  localparam int Z_W         = 32;
  localparam int VEC_W       = 33;
  localparam int PROD_W      = 50;
  localparam int FRAC_BITS   = 30;
  localparam int ATAN_LEN    = 24;
  localparam int RECIP_SHIFT = 48;
  localparam int ANGLE_SHIFT = 8;

  localparam logic [RES_W-1:0]  RES_RESET     = 16'd5000;
  localparam logic [PIDX_W-1:0] FULL_TURN     = 27'd3600000;
  localparam logic [PIDX_W-1:0] THREE_QUARTER = 27'd2700000;
  localparam logic [PIDX_W-1:0] HALF_TURN     = 27'd1800000;
  localparam logic [PIDX_W-1:0] QUARTER_TURN  = 27'd900000;
  // floor(2^48 / 3600000)
  localparam logic [PIDX_W-1:0] RECIP         = 27'd78187493;

  localparam logic signed [VEC_W-1:0] GAIN_START = 33'sd652032874;
  localparam logic signed [OUT_W-1:0] OUT_LIMIT  = 17'sd65535;

  localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'sd115200000, 32'sd68006531, 32'sd35932783, 32'sd18240042,
    32'sd9155416,   32'sd4582171,  32'sd2291645,  32'sd1145892,
    32'sd572955,    32'sd286479,   32'sd143239,   32'sd71620,
    32'sd35810,     32'sd17905,    32'sd8952,     32'sd4476,
    32'sd2238,      32'sd1119,     32'sd560,      32'sd280,
    32'sd140,       32'sd70,       32'sd35,       32'sd17
  };

  typedef struct packed {
    logic [RANGE_W-1:0]      rng;
    logic                    neg;
    logic signed [Z_W-1:0]   z;
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] sy;
  } cordic_word_t;

endpackage
`default_nettype wire

// ===== design/lp2c_angle.sv =====
// Angle front end: index times resolution, modulo a full turn, fold to +-90 deg.
// Five register stages; emits the CORDIC start word. Uses lp2c_pkg.
`default_nettype none
module lp2c_angle #(
  parameter int MAX_BEAMS = 2048
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lp2c_pkg::RANGE_W-1:0] range_mm,
  input  logic [lp2c_pkg::INDEX_W-1:0] beam_index,
  input  logic [lp2c_pkg::RES_W-1:0]   resolution,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lp2c_pkg::cordic_word_t       out_word
);
  import lp2c_pkg::*;

  logic [4:0] vld;
  logic [4:0] en;

  logic [PIDX_W-1:0]   s1_prod;
  logic [RANGE_W-1:0]  s1_rng;
  logic [PIDX_W-1:0]   s2_prod;
  logic [QUO_W-1:0]    s2_quo;
  logic [RANGE_W-1:0]  s2_rng;
  logic [REM_W-1:0]    s3_rem;
  logic [RANGE_W-1:0]  s3_rng;
  logic [ANG_W-1:0]    s4_ang;
  logic [RANGE_W-1:0]  s4_rng;

  logic [2*PIDX_W-1:0] recip_prod;
  logic [PIDX_W-1:0]   rem_full;
  logic                beyond;
  logic signed [Z_W-1:0] fold_ang;
  logic                fold_neg;

  assign en[4]     = !vld[4] || out_ready;
  assign en[3]     = !vld[3] || en[4];
  assign en[2]     = !vld[2] || en[3];
  assign en[1]     = !vld[1] || en[2];
  assign en[0]     = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[4];

  assign beyond     = int'(beam_index) >= MAX_BEAMS;
  assign recip_prod = (2*PIDX_W)'(s1_prod) * (2*PIDX_W)'(RECIP);
  assign rem_full   = s2_prod - PIDX_W'(s2_quo) * FULL_TURN;

  always_comb begin
    if (PIDX_W'(s4_ang) <= QUARTER_TURN) begin
      fold_ang = Z_W'(s4_ang);
      fold_neg = 1'b0;
    end else if (PIDX_W'(s4_ang) < THREE_QUARTER) begin
      fold_ang = $signed(Z_W'(s4_ang)) - $signed(Z_W'(HALF_TURN));
      fold_neg = 1'b1;
    end else begin
      fold_ang = $signed(Z_W'(s4_ang)) - $signed(Z_W'(FULL_TURN));
      fold_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      s1_prod <= PIDX_W'(beam_index) * PIDX_W'(resolution);
      s1_rng  <= beyond ? '0 : range_mm;
    end
    if (en[1] && vld[0]) begin
      s2_prod <= s1_prod;
      s2_quo  <= recip_prod[RECIP_SHIFT +: QUO_W];
      s2_rng  <= s1_rng;
    end
    if (en[2] && vld[1]) begin
      s3_rem <= rem_full[REM_W-1:0];
      s3_rng <= s2_rng;
    end
    if (en[3] && vld[2]) begin
      s4_ang <= (s3_rem >= REM_W'(FULL_TURN)) ? ANG_W'(s3_rem - REM_W'(FULL_TURN))
                                              : ANG_W'(s3_rem);
      s4_rng <= s3_rng;
    end
    if (en[4] && vld[3]) begin
      out_word.rng <= s4_rng;
      out_word.neg <= fold_neg;
      out_word.z   <= fold_ang <<< ANGLE_SHIFT;
      out_word.cx  <= GAIN_START;
      out_word.sy  <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== design/lp2c_cordic_stage.sv =====
// One registered rotation-mode CORDIC iteration with a fixed shift.
// Uses lp2c_pkg for the word type and the arctangent table.
`default_nettype none
module lp2c_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lp2c_pkg::cordic_word_t in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lp2c_pkg::cordic_word_t out_word
);
  import lp2c_pkg::*;

  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;

  assign in_ready = !out_valid || out_ready;
  assign dx = in_word.sy >>> SHIFT;
  assign dy = in_word.cx >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word.rng <= in_word.rng;
      out_word.neg <= in_word.neg;
      if (in_word.z >= 0) begin
        out_word.cx <= in_word.cx - dx;
        out_word.sy <= in_word.sy + dy;
        out_word.z  <= in_word.z - ATAN_TAB[SHIFT];
      end else begin
        out_word.cx <= in_word.cx + dx;
        out_word.sy <= in_word.sy - dy;
        out_word.z  <= in_word.z + ATAN_TAB[SHIFT];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lp2c_scale.sv =====
// Back end: sign fold, range multiply, round half up and saturate to +-65535 mm.
// Three register stages, the last one is the output register. Uses lp2c_pkg.
`default_nettype none
module lp2c_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lp2c_pkg::cordic_word_t            in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lp2c_pkg::OUT_W-1:0] x_mm,
  output logic signed [lp2c_pkg::OUT_W-1:0] y_mm
);
  import lp2c_pkg::*;

  logic [2:0] vld;
  logic [2:0] en;

  logic [RANGE_W-1:0]       s1_rng;
  logic signed [VEC_W-1:0]  s1_s;
  logic signed [VEC_W-1:0]  s1_c;
  logic signed [PROD_W-1:0] s2_p;
  logic signed [PROD_W-1:0] s2_q;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] mul_q;

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0]           t;
    logic signed [PROD_W-FRAC_BITS-1:0] w;
    t = v + PROD_W'(64'd1 << (FRAC_BITS - 1));
    w = t[PROD_W-1:FRAC_BITS];
    if (w > OUT_LIMIT) return OUT_LIMIT;
    else if (w < -OUT_LIMIT) return -OUT_LIMIT;
    else return w[OUT_W-1:0];
  endfunction

  assign en[2]     = !vld[2] || out_ready;
  assign en[1]     = !vld[1] || en[2];
  assign en[0]     = !vld[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = vld[2];

  assign mul_p = PROD_W'($signed({1'b0, s1_rng})) * PROD_W'(s1_s);
  assign mul_q = PROD_W'($signed({1'b0, s1_rng})) * PROD_W'(s1_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      s1_rng <= in_word.rng;
      s1_s   <= in_word.neg ? -in_word.sy : in_word.sy;
      s1_c   <= in_word.neg ? in_word.cx : -in_word.cx;
    end
    if (en[1] && vld[0]) begin
      s2_p <= mul_p;
      s2_q <= mul_q;
    end
    if (en[2] && vld[1]) begin
      x_mm <= round_sat(s2_p);
      y_mm <= round_sat(s2_q);
    end
  end

endmodule
`default_nettype wire

// ===== design/lidar_polar_to_cartesian.sv =====
// Top level of the lidar polar to Cartesian converter.
// Instantiates lp2c_angle, CORDIC_STAGES x lp2c_cordic_stage and lp2c_scale; uses lp2c_pkg.
//
// Converts one beam word (range_mm, beam_index) to x_mm = r*sin(theta) and
// y_mm = -r*cos(theta), theta = beam_index * angular_resolution / 10000 deg.
// Fully pipelined: one word per cycle while out_ready is high, through 5 angle
// stages, one stage per CORDIC iteration and 3 scaling stages. Each stage holds
// under back-pressure and bubbles are squeezed out. Beams at or beyond
// MAX_BEAMS give (0, 0). The resolution register resets to 5000 and is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while no word is
// in flight, as the block itself does not enforce this.
`default_nettype none
module lidar_polar_to_cartesian #(
  parameter int MAX_BEAMS     = 2048,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lp2c_pkg::RES_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lp2c_pkg::RANGE_W-1:0]      range_mm,
  input  logic [lp2c_pkg::INDEX_W-1:0]      beam_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lp2c_pkg::OUT_W-1:0] x_mm,
  output logic signed [lp2c_pkg::OUT_W-1:0] y_mm
);
  import lp2c_pkg::*;

  logic [RES_W-1:0]       angular_resolution;
  cordic_word_t           cw    [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] cv;
  logic [CORDIC_STAGES:0] cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      angular_resolution <= RES_RESET;
    end else if (cfg_wr_en) begin
      angular_resolution <= cfg_wr_data;
    end
  end

  lp2c_angle #(
    .MAX_BEAMS(MAX_BEAMS)
  ) u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .range_mm  (range_mm),
    .beam_index(beam_index),
    .resolution(angular_resolution),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_word  (cw[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    lp2c_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[i]),
      .in_ready (cr[i]),
      .in_word  (cw[i]),
      .out_valid(cv[i+1]),
      .out_ready(cr[i+1]),
      .out_word (cw[i+1])
    );
  end

  lp2c_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[CORDIC_STAGES]),
    .in_ready (cr[CORDIC_STAGES]),
    .in_word  (cw[CORDIC_STAGES]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .x_mm     (x_mm),
    .y_mm     (y_mm)
  );

endmodule
`default_nettype wire

// ===== design/lp2c_checker.sv =====
// Port-level checker for lidar_polar_to_cartesian, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none
module lp2c_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [16:0] x_mm,
  input logic signed [16:0] y_mm
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_mm) && $stable(y_mm))
    else $error("output word changed while stalled");

  a_x_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> x_mm != -17'sd65536)
    else $error("x_mm outside saturation range");

  a_y_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> y_mm != -17'sd65536)
    else $error("y_mm outside saturation range");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind lidar_polar_to_cartesian lp2c_checker u_checker (.*);
`default_nettype wire
